// ----- rtl/llpp_pkg.sv -----
// Package for the lossy line proximal projection block.
// Holds payload structs, register indexes, Q32.32 constants, ALU op codes and a saturation helper.
// No dependencies.
package llpp_pkg;

    typedef struct packed {
        logic signed [63:0] power_a;
        logic signed [63:0] dual_a;
        logic signed [63:0] power_b;
        logic signed [63:0] dual_b;
        logic               last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] new_power_a;
        logic signed [63:0] new_power_b;
        logic               last_out;
    } t_out_item;

    localparam logic [2:0] REG_RHO     = 3'd0;
    localparam logic [2:0] REG_EPSILON = 3'd1;
    localparam logic [2:0] REG_COND    = 3'd2;
    localparam logic [2:0] REG_LSUM    = 3'd3;
    localparam logic [2:0] REG_LDIFF   = 3'd4;
    localparam logic [2:0] REG_BETA_SQ = 3'd5;
    localparam logic [2:0] REG_BOUND   = 3'd6;

    localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MEAN = 3'd4
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    function automatic logic signed [63:0] sat_mag(input logic neg, input logic [63:0] m);
        logic signed [63:0] r;
        if (!neg) r = m[63] ? S_MAX : $signed(m);
        else if (m[63]) r = S_MIN;
        else r = -$signed(m);
        return r;
    endfunction

endpackage

// ----- rtl/lossy_line_prox_projection.sv -----
// Lossy line proximal projection: Q32.32 saturating math on one shared ALU.
// Three cases: a corner clamp, a point inside the ellipse, or a bisection over
// BISECTION_STEPS steps outside it. One beat in flight: a new beat is accepted once
// the result enters the output register and busy clears, unless a register write
// is waiting, which goes first. Reset (synchronous, active low) restores register
// defaults, empties output.
// Depends on llpp_pkg, llpp_alu, llpp_seq.
module lossy_line_prox_projection #(
    parameter int BISECTION_STEPS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  llpp_pkg::t_in_item    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output llpp_pkg::t_out_item   o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data
);
    import llpp_pkg::*;

    logic signed [63:0] r_rho, r_eps, r_g, r_lsum, r_ldiff, r_bs, r_bound;
    t_in_item  r_item;
    logic      r_busy;
    logic      r_ovalid;
    t_out_item r_out;
    t_alu_req  w_req;
    t_alu_stat w_stat;
    logic signed [63:0] w_a, w_b, w_res, w_pa, w_pb;
    logic w_done, w_start, w_hold, w_fire;

    // accept a new beat only when nothing is in flight; a register write goes first
    assign o_ready = !r_busy && !i_cfg_valid;
    assign w_start = i_valid && o_ready;
    // take register writes only between items
    assign o_cfg_ready = !r_busy;
    // hold the finished result while the output register is still full
    assign w_hold = r_ovalid && !i_ready;
    assign w_fire = w_done && !w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho <= Q_ONE; r_eps <= 64'sd4295; r_g <= Q_ONE; r_lsum <= Q_ONE;
            r_ldiff <= Q_ONE; r_bs <= Q_ONE; r_bound <= '0;
            r_busy <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_RHO:     r_rho   <= {1'b0, i_cfg_data[62:0]};
                    REG_EPSILON: r_eps   <= {1'b0, i_cfg_data[62:0]};
                    REG_COND:    r_g     <= {1'b0, i_cfg_data[62:0]};
                    REG_LSUM:    r_lsum  <= i_cfg_data;
                    REG_LDIFF:   r_ldiff <= i_cfg_data;
                    REG_BETA_SQ: r_bs    <= {1'b0, i_cfg_data[62:0]};
                    REG_BOUND:   r_bound <= i_cfg_data;
                    default:     r_rho   <= r_rho;   // drop writes past the list
                endcase
            end
            if (w_start) r_busy <= 1'b1;
            else if (w_fire) r_busy <= 1'b0;
            // hold the result until the sink takes it
            if (w_fire) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (w_start) r_item <= i_data;
        if (w_fire) begin
            r_out.new_power_a <= w_pa;
            r_out.new_power_b <= w_pb;
            r_out.last_out    <= r_item.last_in;
        end
    end

    llpp_seq #(.BISECTION_STEPS(BISECTION_STEPS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_hold(w_hold),
        .i_item(r_item),
        .i_rho(r_rho), .i_eps(r_eps), .i_g(r_g), .i_lsum(r_lsum), .i_ldiff(r_ldiff),
        .i_bs(r_bs), .i_bound(r_bound), .i_alu_stat(w_stat), .i_alu_res(w_res),
        .o_alu_req(w_req), .o_alu_a(w_a), .o_alu_b(w_b), .o_done(w_done),
        .o_pa(w_pa), .o_pb(w_pb)
    );

    llpp_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_a(w_a), .i_b(w_b),
        .o_stat(w_stat), .o_res(w_res)
    );

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("accept while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_valid) else $error("result lost");
    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy) else $error("result without item");
`endif

endmodule

// ----- rtl/llpp_alu.sv -----
// Shared Q32.32 arithmetic unit: saturating add/sub and a mean of two operands,
// multiply from four 32x32 partial products, divide one quotient bit a cycle.
// Depends on llpp_pkg.
module llpp_alu (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  llpp_pkg::t_alu_req     i_req,
    input  logic signed [63:0]     i_a,
    input  logic signed [63:0]     i_b,
    output llpp_pkg::t_alu_stat    o_stat,
    output logic signed [63:0]     o_res
);
    import llpp_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_DONE = 4'b1000
    } t_astate;

    t_astate r_st, n_st;
    logic [63:0] r_x, n_x, r_y, n_y;
    logic        r_neg, n_neg;
    logic [127:0] r_acc, n_acc;
    logic [6:0]  r_cnt, n_cnt;
    logic [64:0] r_rem, n_rem;
    logic [95:0] r_num, n_num;
    logic signed [63:0] r_res, n_res;

    logic signed [64:0] w_sum, w_dif, w_mean;
    logic [63:0] w_ma, w_mb;
    logic [31:0] w_xp, w_yp;
    logic [63:0] w_pp;
    logic [64:0] w_sh;
    logic [6:0]  w_pp_shift;

    always_comb begin
        w_sum  = {i_a[63], i_a} + {i_b[63], i_b};
        w_dif  = {i_a[63], i_a} - {i_b[63], i_b};
        w_mean = w_sum >>> 1;
        w_ma   = i_a[63] ? 64'(-i_a) : i_a;
        w_mb   = i_b[63] ? 64'(-i_b) : i_b;
        w_xp   = r_cnt[1] ? r_x[63:32] : r_x[31:0];
        w_yp   = r_cnt[0] ? r_y[63:32] : r_y[31:0];
        w_pp   = w_xp * w_yp;
        w_sh   = {r_rem[63:0], r_num[95]};
        w_pp_shift = ({6'd0, r_cnt[1]} + {6'd0, r_cnt[0]}) * 7'd32;
    end

    always_comb begin
        n_st = r_st; n_x = r_x; n_y = r_y; n_neg = r_neg; n_acc = r_acc;
        n_cnt = r_cnt; n_rem = r_rem; n_num = r_num; n_res = r_res;
        unique case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    n_x = w_ma; n_y = w_mb; n_neg = i_a[63] ^ i_b[63];
                    n_acc = '0; n_cnt = '0; n_rem = '0; n_num = {w_ma, 32'd0};
                    unique case (i_req.op)
                        OP_ADD: begin
                            n_res = (w_sum[64] != w_sum[63]) ? (w_sum[64] ? S_MIN : S_MAX)
                                                               : w_sum[63:0];
                            n_st = A_DONE;
                        end
                        OP_SUB: begin
                            n_res = (w_dif[64] != w_dif[63]) ? (w_dif[64] ? S_MIN : S_MAX)
                                                               : w_dif[63:0];
                            n_st = A_DONE;
                        end
                        OP_MEAN: begin
                            n_res = w_mean[63:0];
                            n_st = A_DONE;
                        end
                        OP_MUL: n_st = A_MUL;
                        OP_DIV: begin
                            if (w_mb == '0) begin
                                n_res = (i_a == '0) ? '0 : (i_a[63] ? S_MIN : S_MAX);
                                n_st = A_DONE;
                            end else begin
                                n_st = A_DIV;
                            end
                        end
                        default: begin
                            n_res = '0;
                            n_st = A_DONE;
                        end
                    endcase
                end
            end
            A_MUL: begin
                // accumulate one partial product per cycle
                n_acc = r_acc + ({64'd0, w_pp} << w_pp_shift);
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd3) begin
                    n_st = A_DONE;
                    n_res = (n_acc[127:96] != '0) ? (r_neg ? S_MIN : S_MAX)
                                                  : sat_mag(r_neg, n_acc[95:32]);
                end
            end
            A_DIV: begin
                // restoring division, one quotient bit per cycle
                n_num = {r_num[94:0], 1'b0};
                if (w_sh >= {1'b0, r_y}) begin
                    n_rem = w_sh - {1'b0, r_y};
                    n_acc = {r_acc[126:0], 1'b1};
                end else begin
                    n_rem = w_sh;
                    n_acc = {r_acc[126:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd95) begin
                    n_st = A_DONE;
                    n_res = (n_acc[95:64] != '0) ? (r_neg ? S_MIN : S_MAX)
                                                 : sat_mag(r_neg, n_acc[63:0]);
                end
            end
            A_DONE: n_st = A_IDLE;
            default: n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_x <= n_x; r_y <= n_y; r_neg <= n_neg; r_acc <= n_acc;
        r_cnt <= n_cnt; r_rem <= n_rem; r_num <= n_num; r_res <= n_res;
    end

    assign o_stat.busy = (r_st != A_IDLE);
    assign o_stat.done = (r_st == A_DONE);
    assign o_res = r_res;

endmodule

// ----- rtl/llpp_seq.sv -----
// Sequencer for the projection: walks the micro-program over the shared ALU.
// Depends on llpp_pkg; drives llpp_alu through its request/status structs.
module llpp_seq #(
    parameter int BISECTION_STEPS = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_hold,
    input  llpp_pkg::t_in_item      i_item,
    input  logic signed [63:0]      i_rho,
    input  logic signed [63:0]      i_eps,
    input  logic signed [63:0]      i_g,
    input  logic signed [63:0]      i_lsum,
    input  logic signed [63:0]      i_ldiff,
    input  logic signed [63:0]      i_bs,
    input  logic signed [63:0]      i_bound,
    input  llpp_pkg::t_alu_stat     i_alu_stat,
    input  logic signed [63:0]      i_alu_res,
    output llpp_pkg::t_alu_req      o_alu_req,
    output logic signed [63:0]      o_alu_a,
    output logic signed [63:0]      o_alu_b,
    output logic                    o_done,
    output logic signed [63:0]      o_pa,
    output logic signed [63:0]      o_pb
);
    import llpp_pkg::*;

    localparam int KW = $clog2(BISECTION_STEPS + 1);

    // micro-op steps
    typedef enum logic [5:0] {
        S_IDLE, S_T0, S_S, S_D1, S_V1, S_D2, S_V2, S_G2, S_DF, S_U, S_SM, S_V,
        S_CLIP, S_MV, S_UB, S_LU, S_VM1, S_BV, S_VV, S_UU, S_LUU, S_CT,
        S_I1, S_I2, S_H1, S_H2, S_H3, S_H4, S_LO, S_B4,
        S_LAM, S_T1, S_T2, S_S1, S_S2, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_TE,
        S_F1, S_F2, S_FU, S_F3, S_F4, S_FV, S_SIGN, S_O1, S_O2, S_O3, S_O4, S_END
    } t_step;

    t_step r_pc, n_pc;
    logic  r_issued, n_issued;
    logic signed [63:0] r_t0, r_t1, r_t2, r_u, r_v, r_vv, r_uu, r_ub, r_lu, r_b4;
    logic signed [63:0] r_hi, r_lo, r_lam, r_s1, r_s2;
    logic signed [63:0] n_t0, n_t1, n_t2, n_u, n_v, n_vv, n_uu, n_ub, n_lu, n_b4;
    logic signed [63:0] n_hi, n_lo, n_lam, n_s1, n_s2;
    logic r_pos, n_pos;
    logic [KW-1:0] r_k, n_k;
    t_op w_op;
    logic signed [63:0] w_a, w_b, w_r;

    // operands and op of each step
    always_comb begin
        w_op = OP_ADD; w_a = '0; w_b = '0;
        unique case (r_pc)
            S_T0:  begin w_op = OP_ADD; w_a = i_rho; w_b = i_eps; end
            S_S:   begin w_op = OP_DIV; w_a = i_rho; w_b = r_t0; end
            S_D1:  begin w_op = OP_SUB; w_a = i_item.power_a; w_b = i_item.dual_a; end
            S_V1:  begin w_op = OP_MUL; w_a = r_t2; w_b = r_t0; end
            S_D2:  begin w_op = OP_SUB; w_a = i_item.power_b; w_b = i_item.dual_b; end
            S_V2:  begin w_op = OP_MUL; w_a = r_t2; w_b = r_t0; end
            S_G2:  begin w_op = OP_ADD; w_a = i_g; w_b = i_g; end
            S_DF:  begin w_op = OP_SUB; w_a = r_u; w_b = r_v; end
            S_U:   begin w_op = OP_DIV; w_a = r_t0; w_b = r_t1; end
            S_SM:  begin w_op = OP_ADD; w_a = r_u; w_b = r_v; end
            S_V:   begin w_op = OP_DIV; w_a = r_t0; w_b = r_t1; end
            S_CLIP: begin w_op = OP_SUB; w_a = '0; w_b = r_u; end
            S_MV:  begin w_op = OP_MUL; w_a = i_ldiff; w_b = r_v; end
            S_UB:  begin w_op = OP_DIV; w_a = r_t0; w_b = i_bs; end
            S_LU:  begin w_op = OP_ADD; w_a = i_bound; w_b = r_t0; end
            S_VM1: begin w_op = OP_MUL; w_a = i_lsum; w_b = r_u; end
            S_BV:  begin w_op = OP_SUB; w_a = r_v; w_b = Q_ONE; end
            S_VV:  begin w_op = OP_MUL; w_a = i_bs; w_b = r_t1; end
            S_UU:  begin w_op = OP_MUL; w_a = r_t0; w_b = r_t1; end
            S_LUU: begin w_op = OP_MUL; w_a = r_u; w_b = r_u; end
            S_CT:  begin w_op = OP_SUB; w_a = r_lu; w_b = r_u; end
            S_I1:  begin w_op = OP_ADD; w_a = r_vv; w_b = r_uu; end
            S_I2:  begin w_op = OP_SUB; w_a = r_t0; w_b = i_bs; end
            S_H1:  begin w_op = OP_MUL; w_a = i_ldiff; w_b = r_v; end
            S_H2:  begin w_op = OP_SUB; w_a = r_lu; w_b = r_t0; end
            S_H3:  begin w_op = OP_SUB; w_a = i_ldiff; w_b = r_lu; end
            S_H4:  begin w_op = OP_DIV; w_a = r_t1; w_b = r_t0; end
            S_LO:  begin w_op = OP_SUB; w_a = '0; w_b = r_v; end
            S_B4:  begin w_op = OP_MUL; w_a = i_bs; w_b = i_bs; end
            S_LAM: begin w_op = OP_MEAN; w_a = r_hi; w_b = r_lo; end
            S_T1:  begin w_op = OP_ADD; w_a = r_lam; w_b = i_bs; end
            S_T2:  begin w_op = OP_ADD; w_a = Q_ONE; w_b = r_lam; end
            S_S1:  begin w_op = OP_MUL; w_a = r_t1; w_b = r_t1; end
            S_S2:  begin w_op = OP_MUL; w_a = r_t2; w_b = r_t2; end
            S_P1:  begin w_op = OP_MUL; w_a = r_s1; w_b = r_vv; end
            S_P2:  begin w_op = OP_MUL; w_a = r_b4; w_b = r_uu; end
            S_P3:  begin w_op = OP_MUL; w_a = r_t1; w_b = r_s2; end
            S_P4:  begin w_op = OP_ADD; w_a = r_t0; w_b = r_t1; end
            S_P5:  begin w_op = OP_MUL; w_a = i_bs; w_b = r_s1; end
            S_P6:  begin w_op = OP_MUL; w_a = r_t1; w_b = r_s2; end
            S_TE:  begin w_op = OP_SUB; w_a = r_t0; w_b = r_t1; end
            S_F1:  begin w_op = OP_MUL; w_a = i_bs; w_b = r_u; end
            S_F2:  begin w_op = OP_ADD; w_a = r_lam; w_b = i_bs; end
            S_FU:  begin w_op = OP_DIV; w_a = r_t0; w_b = r_t1; end
            S_F3:  begin w_op = OP_ADD; w_a = r_v; w_b = r_lam; end
            S_F4:  begin w_op = OP_ADD; w_a = Q_ONE; w_b = r_lam; end
            S_FV:  begin w_op = OP_DIV; w_a = r_t0; w_b = r_t1; end
            S_SIGN: begin w_op = OP_SUB; w_a = '0; w_b = r_u; end
            S_O1:  begin w_op = OP_ADD; w_a = r_v; w_b = r_u; end
            S_O2:  begin w_op = OP_MUL; w_a = i_g; w_b = r_t0; end
            S_O3:  begin w_op = OP_SUB; w_a = r_v; w_b = r_u; end
            S_O4:  begin w_op = OP_MUL; w_a = i_g; w_b = r_t0; end
            default: begin w_op = OP_ADD; w_a = '0; w_b = '0; end
        endcase
    end

    always_comb begin
        n_pc = r_pc; n_issued = r_issued;
        n_t0 = r_t0; n_t1 = r_t1; n_t2 = r_t2; n_u = r_u; n_v = r_v; n_vv = r_vv;
        n_uu = r_uu; n_ub = r_ub; n_lu = r_lu; n_b4 = r_b4; n_hi = r_hi; n_lo = r_lo;
        n_lam = r_lam; n_s1 = r_s1; n_s2 = r_s2; n_pos = r_pos; n_k = r_k;
        w_r = i_alu_res;
        if (r_pc == S_IDLE) begin
            if (i_start) begin
                n_pc = S_T0;
                n_issued = 1'b0;
            end
        end else if (r_pc == S_END) begin
            // hold the finished result while the output register is still full
            if (!i_hold) n_pc = S_IDLE;
        end else if (!r_issued) begin
            n_issued = 1'b1;
        end else if (i_alu_stat.done) begin
            n_issued = 1'b0;
            n_pc = t_step'(r_pc + 6'd1);
            unique case (r_pc)
                S_T0: n_t0 = w_r;
                S_S:  n_t0 = w_r;        // s
                S_D1: n_t2 = w_r;
                S_V1: n_u = w_r;         // v1
                S_D2: n_t2 = w_r;
                S_V2: n_v = w_r;         // v2
                S_G2: n_t1 = w_r;        // 2g
                S_DF: n_t0 = w_r;
                S_U:  n_t2 = w_r;        // u until v is formed
                S_SM: n_t0 = w_r;
                S_V: begin
                    n_u = r_t2;
                    n_pos = !r_t2[63];
                    n_v = ($signed(w_r) >= i_lsum) ? i_lsum : w_r;
                end
                S_CLIP: if (r_u <= 0) n_u = w_r;
                S_MV: n_t0 = w_r;
                S_UB: n_t0 = w_r;
                S_LU: n_ub = w_r;
                S_VM1: n_lu = w_r;
                S_BV: n_t1 = w_r;        // v-1
                S_VV: n_t0 = w_r;
                S_UU: n_vv = w_r;
                S_LUU: n_uu = w_r;
                S_CT: begin
                    if (w_r <= r_ub) begin
                        n_u = i_ldiff; n_v = i_lsum; n_pc = S_SIGN;
                    end
                end
                S_I1: n_t0 = w_r;
                S_I2: if (w_r <= 0) n_pc = S_SIGN;
                S_H1: n_t0 = w_r;
                S_H2: n_t1 = w_r;
                S_H3: n_t0 = w_r;
                S_H4: n_hi = w_r;
                S_LO: n_lo = w_r[63] ? '0 : w_r;
                S_B4: begin n_b4 = w_r; n_k = '0; end
                S_LAM: n_lam = w_r;
                S_T1: n_t1 = w_r;
                S_T2: n_t2 = w_r;
                S_S1: n_s1 = w_r;
                S_S2: n_s2 = w_r;
                S_P1: n_t0 = w_r;
                S_P2: n_t1 = w_r;
                S_P3: n_t1 = w_r;
                S_P4: n_t0 = w_r;
                S_P5: n_t1 = w_r;
                S_P6: n_t1 = w_r;
                S_TE: begin
                    if (w_r <= 0) n_hi = r_lam;
                    else n_lo = r_lam;
                    n_k = r_k + KW'(1);
                    if (r_k != KW'(BISECTION_STEPS - 1)) n_pc = S_LAM;
                end
                S_F1: n_t0 = w_r;
                S_F2: n_t1 = w_r;
                S_FU: n_u = w_r;
                S_F3: n_t0 = w_r;
                S_F4: n_t1 = w_r;
                S_FV: n_v = w_r;
                S_SIGN: if (!r_pos) n_u = w_r;
                S_O1: n_t0 = w_r;
                S_O2: n_s1 = w_r;
                S_O3: n_t0 = w_r;
                S_O4: n_s2 = w_r;
                default: n_t0 = r_t0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_pc <= n_pc;
            r_issued <= n_issued;
        end
        r_t0 <= n_t0; r_t1 <= n_t1; r_t2 <= n_t2; r_u <= n_u; r_v <= n_v;
        r_vv <= n_vv; r_uu <= n_uu; r_ub <= n_ub; r_lu <= n_lu; r_b4 <= n_b4;
        r_hi <= n_hi; r_lo <= n_lo; r_lam <= n_lam; r_s1 <= n_s1; r_s2 <= n_s2;
        r_pos <= n_pos; r_k <= n_k;
    end

    assign o_alu_req.start = (r_pc != S_IDLE) && (r_pc != S_END) && !r_issued;
    assign o_alu_req.op = w_op;
    assign o_alu_a = w_a;
    assign o_alu_b = w_b;
    assign o_done = (r_pc == S_END);
    assign o_pa = r_s1;
    assign o_pb = r_s2;

endmodule

// ----- test/tb_top.sv -----
// Testbench for lossy_line_prox_projection: drives item and register beats and the result ready,
// predicts each projected result in Q32.32 and compares it field by field.
// Depends on llpp_pkg and the lossy_line_prox_projection RTL.
`timescale 1ns / 100ps

module tb_top;
    import llpp_pkg::*;

    localparam int BISECT   = 40;
    localparam int WD_LIMIT = 60000;     // idle cycles before the run is declared hung
    localparam int LONG_HOLD = 3000;     // receiver hold-off in the pressure test
    localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_RHO;
    logic [63:0] i_cfg_data = '0;

    // Shadow copies of the block's registers
    logic signed [63:0] sh_rho, sh_eps, sh_g, sh_lsum, sh_ldiff, sh_bsq, sh_bound;

    t_out_item expected_proj[$];
    int n_fail = 0;
    int n_sent = 0;
    int n_seen = 0;
    int n_cfg = 0;
    int hold_token = 0;

    lossy_line_prox_projection #(.BISECTION_STEPS(BISECT)) i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- Q32.32 saturating arithmetic ----------------
    function automatic logic signed [63:0] sat_mag_of(input logic neg, input logic [63:0] m);
        if (!neg) return m[63] ? S_MAX : $signed(m);
        if (m[63]) return S_MIN;
        return -$signed(m);
    endfunction

    function automatic logic [63:0] abs_u(input logic signed [63:0] a);
        return a[63] ? 64'(0) - a : a;
    endfunction

    function automatic logic signed [63:0] qadd(input logic signed [63:0] a, b);
        logic signed [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? S_MIN : S_MAX;
        return r;
    endfunction

    function automatic logic signed [63:0] qsub(input logic signed [63:0] a, b);
        logic signed [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? S_MIN : S_MAX;
        return r;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a, b);
        logic [127:0] p;
        logic neg;
        neg = a[63] ^ b[63];
        p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
        // truncate magnitude, saturate when it does not fit a signed 64-bit result
        if (p[127:96] != 0) return neg ? S_MIN : S_MAX;
        return sat_mag_of(neg, p[95:32]);
    endfunction

    function automatic logic signed [63:0] qdiv(input logic signed [63:0] a, b);
        logic [95:0] q;
        logic neg;
        neg = a[63] ^ b[63];
        if (b == 0) begin
            if (a == 0) return 0;
            return a[63] ? S_MIN : S_MAX;
        end
        q = {abs_u(a), 32'd0} / {32'd0, abs_u(b)};
        if (q[95:64] != 0) return neg ? S_MIN : S_MAX;
        return sat_mag_of(neg, q[63:0]);
    endfunction

    function automatic logic signed [63:0] qmean(input logic signed [63:0] a, b);
        return (a >>> 1) + (b >>> 1) + $signed({63'd0, a[0] & b[0]});
    endfunction

    // ---------------- projection predictor ----------------
    function automatic t_out_item project_line(input t_in_item it);
        t_out_item r;
        logic signed [63:0] sc, w1, w2, twog, du, sv, ub, lu, vm1, vv, uu;
        logic signed [63:0] lam_hi, lam_lo, lam, b4, t1, t2, s1, s2, crit;
        logic pos;
        sc   = qdiv(sh_rho, qadd(sh_rho, sh_eps));
        w1   = qmul(sc, qsub(it.power_a, it.dual_a));
        w2   = qmul(sc, qsub(it.power_b, it.dual_b));
        twog = qadd(sh_g, sh_g);
        du   = qdiv(qsub(w1, w2), twog);
        sv   = qdiv(qadd(w1, w2), twog);
        pos  = !du[63];
        if (sv >= sh_lsum) sv = sh_lsum;
        if (du <= 0) du = qsub(0, du);
        ub  = qadd(sh_bound, qdiv(qmul(sh_ldiff, sv), sh_bsq));
        lu  = qmul(sh_lsum, du);
        vm1 = qsub(sv, Q_ONE);
        vv  = qmul(qmul(sh_bsq, vm1), vm1);
        uu  = qmul(du, du);
        if (qsub(lu, du) <= ub) begin
            // clamp to the corner
            du = sh_ldiff;
            sv = sh_lsum;
        end else if (qsub(qadd(vv, uu), sh_bsq) > 0) begin
            // outside the ellipse: bisect on the multiplier
            lam_hi = qdiv(qsub(lu, qmul(sh_ldiff, sv)), qsub(sh_ldiff, lu));
            lam_lo = qsub(0, sv);
            if (lam_lo < 0) lam_lo = 0;
            b4  = qmul(sh_bsq, sh_bsq);
            lam = qmean(lam_hi, lam_lo);
            for (int k = 0; k < BISECT; k++) begin
                lam  = qmean(lam_hi, lam_lo);
                t1   = qadd(lam, sh_bsq);
                t2   = qadd(Q_ONE, lam);
                s1   = qmul(t1, t1);
                s2   = qmul(t2, t2);
                crit = qsub(qadd(qmul(s1, vv), qmul(qmul(b4, uu), s2)),
                            qmul(qmul(sh_bsq, s1), s2));
                if (crit <= 0) lam_hi = lam;
                else lam_lo = lam;
            end
            du = qdiv(qmul(sh_bsq, du), qadd(lam, sh_bsq));
            sv = qdiv(qadd(sv, lam), qadd(Q_ONE, lam));
        end
        if (!pos) du = qsub(0, du);
        r.new_power_a = qmul(sh_g, qadd(sv, du));
        r.new_power_b = qmul(sh_g, qsub(sv, du));
        r.last_out    = it.last_in;
        return r;
    endfunction

    // ---------------- result side: random ready, checking ----------------
    int rx_stall = 0;
    int rx_token_seen = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            // accept the beat offered before this edge
            if (o_valid && i_ready) begin
                n_seen++;
                if (expected_proj.size() == 0) begin
                    $error("result beat with nothing expected: %h", o_data);
                    n_fail++;
                end else begin
                    want = expected_proj.pop_front();
                    if (o_data.new_power_a !== want.new_power_a) begin
                        $error("new_power_a exp %h got %h", want.new_power_a, o_data.new_power_a);
                        n_fail++;
                    end
                    if (o_data.new_power_b !== want.new_power_b) begin
                        $error("new_power_b exp %h got %h", want.new_power_b, o_data.new_power_b);
                        n_fail++;
                    end
                    if (o_data.last_out !== want.last_out) begin
                        $error("last_out exp %b got %b", want.last_out, o_data.last_out);
                        n_fail++;
                    end
                end
            end
            // pick the next ready value: a requested long hold wins
            if (hold_token != rx_token_seen) begin
                rx_token_seen = hold_token;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 25) begin
                rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                        : $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog: count cycles with no beat ----------------
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WD_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- shared driving tasks ----------------
    task automatic send_item(input t_in_item it, input int gap);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        // beat accepted at this edge: predict with the registers in force now
        expected_proj.push_back(project_line(it));
        n_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The line stays valid after the last beat until the caller drops it here.
    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            REG_RHO:     sh_rho   = val & MASK63;
            REG_EPSILON: sh_eps   = val & MASK63;
            REG_COND:    sh_g     = val & MASK63;
            REG_LSUM:    sh_lsum  = val;
            REG_LDIFF:   sh_ldiff = val;
            REG_BETA_SQ: sh_bsq   = val & MASK63;
            REG_BOUND:   sh_bound = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drain: every item yields a result, so empty means idle; then settle.
    task automatic drain();
        drop_valid();
        while (expected_proj.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // Q32.32 value with a random integer part in [-lim, lim] and random fraction
    function automatic logic [63:0] rand_q(input int lim);
        int k;
        k = int'($urandom_range(0, 2 * lim)) - lim;
        return {32'(k), 32'($urandom)};
    endfunction

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item mk_item(input logic [63:0] pa, da, pb, db, input logic lst);
        t_in_item it;
        it.power_a = pa;
        it.dual_a  = da;
        it.power_b = pb;
        it.dual_b  = db;
        it.last_in = lst;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        if ($urandom_range(0, 9) == 0)
            it = mk_item(rand_wide(), rand_wide(), rand_wide(), rand_wide(), 1'b0);
        else
            it = mk_item(rand_q(6), rand_q(2), rand_q(6), rand_q(2), 1'b0);
        it.last_in = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // ---------------- tests ----------------
    // Field extremes and each projection case under chosen registers.
    task automatic test_directed();
        logic [63:0] one, mx, mn;
        one = Q_ONE;
        mx  = S_MAX;
        mn  = S_MIN;
        // defaults after reset
        send_item(mk_item(0, 0, 0, 0, 1'b0), 0);
        send_item(mk_item(mx, mn, mn, mx, 1'b1), 0);
        send_item(mk_item(mn, mx, mx, mn, 1'b0), 1);
        send_item(mk_item(mx, mx, mn, mn, 1'b1), 0);
        send_item(mk_item(-64'sd1, 0, 64'sd1, 0, 1'b0), 2);
        // corner clamp: small u, v inside the cap
        send_item(mk_item(one, 0, one, 0, 1'b0), 0);
        // inside the ellipse with a widened cap
        drain();
        write_reg(REG_LSUM, 64'sh0000_0004_0000_0000);
        write_reg(REG_BOUND, -64'sh0000_0010_0000_0000);
        send_item(mk_item(64'sh0000_0002_0000_0000, 0, 64'sh0000_0001_8000_0000, 0, 1'b0), 0);
        // outside the ellipse: bisection
        send_item(mk_item(64'sh0000_0006_0000_0000, 0, -64'sh0000_0003_0000_0000, 0, 1'b1), 0);
        send_item(mk_item(-64'sh0000_0006_0000_0000, 0, 64'sh0000_0002_0000_0000, 0, 1'b0), 3);
        // bisection with a zero divisor in the upper multiplier bound (M == L*u)
        drain();
        write_reg(REG_EPSILON, 0);
        write_reg(REG_LSUM, one);
        write_reg(REG_LDIFF, one);
        send_item(mk_item(one, 0, -64'sh1_0000_0000, 0, 1'b0), 0);
        send_item(mk_item(0, -64'sh1_0000_0000, 0, one, 1'b1), 0);
        drain();
    endtask

    // Each register at its extremes, with a handful of items per setting.
    task automatic test_reg_extremes();
        logic [63:0] lo_v[7], hi_v[7];
        lo_v = '{64'd1, 64'd0, 64'd1, S_MIN, S_MIN, 64'd1, S_MIN};
        hi_v = '{MASK63, MASK63, MASK63, S_MAX, S_MAX, MASK63, S_MAX};
        for (int r = 0; r < 7; r++) begin
            for (int e = 0; e < 2; e++) begin
                write_reg(3'(r), e ? hi_v[r] : lo_v[r]);
                repeat (4) send_item(rand_item(), pick_gap());
                drain();
            end
            // also write each register with the top bit set; the 63-bit ones must ignore it
            write_reg(3'(r), 64'h8000_0001_0000_0000);
            repeat (2) send_item(rand_item(), pick_gap());
            drain();
        end
    endtask

    // Random register phases with random items and random gaps.
    task automatic test_random(input int n_phase, input int per_phase);
        for (int p = 0; p < n_phase; p++) begin
            write_reg(REG_RHO,     {1'b0, 31'($urandom_range(0, 3)), 32'($urandom)} | 64'd1);
            write_reg(REG_EPSILON, ($urandom_range(0, 3) == 0) ? 64'd0 : {48'd0, 16'($urandom)});
            write_reg(REG_COND,    {30'd0, 2'($urandom_range(0, 2)), 32'($urandom)} | 64'd1);
            write_reg(REG_LSUM,    rand_q(3));
            write_reg(REG_LDIFF,   rand_q(3));
            write_reg(REG_BETA_SQ, {30'd0, 2'($urandom_range(0, 2)), 32'($urandom)} | 64'd1);
            write_reg(REG_BOUND,   ($urandom_range(0, 1) == 0) ? rand_q(4) : 64'd0);
            for (int i = 0; i < per_phase; i++) begin
                // a stretch of back-to-back beats now and then
                if ((i % 40) < 8) send_item(rand_item(), 0);
                else send_item(rand_item(), pick_gap());
            end
            drain();
        end
    endtask

    // Hold the receiver off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_token <= hold_token + 1;
        @(posedge i_clk);
        repeat (12) send_item(rand_item(), 0);
        drain();
    endtask

    initial begin
        sh_rho   = Q_ONE;
        sh_eps   = 64'sd4295;
        sh_g     = Q_ONE;
        sh_lsum  = Q_ONE;
        sh_ldiff = Q_ONE;
        sh_bsq   = Q_ONE;
        sh_bound = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_reg_extremes();
        test_random(8, 200);
        test_backpressure();

        drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d item beats, %0d result beats, %0d register writes,", n_sent,
                 n_seen, n_cfg);
        $display("all three projection cases, register extremes and a long receiver stall");
        if (n_fail == 0 && expected_proj.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
